// ===== rtl/core/tql_pkg.sv =====
// Shared types and constants for the tabular Q-learning agent.
// Used by tql_ctrl, tql_dp and tabular_q_learning_agent; depends on nothing.

package tql_pkg;

   // Table geometry: one row per state, two signed Q16.16 action values per row.
   localparam int NUM_STATES = 128;
   localparam int STATE_W    = $clog2(NUM_STATES);
   localparam int Q_W        = 32;
   localparam int ROW_W      = 2 * Q_W;

   localparam int REWARD_W   = 11;
   localparam int PCT_W      = 7;
   localparam int COEF_W     = 16;

   // Request payload layout, lowest bit first.
   localparam int REQ_CUR_LSB  = 0;
   localparam int REQ_ACT_LSB  = REQ_CUR_LSB + STATE_W;
   localparam int REQ_RWD_LSB  = REQ_ACT_LSB + 1;
   localparam int REQ_NXT_LSB  = REQ_RWD_LSB + REWARD_W;
   localparam int REQ_PCT_LSB  = REQ_NXT_LSB + STATE_W;
   localparam int REQ_RBIT_LSB = REQ_PCT_LSB + PCT_W;
   localparam int REQ_USED_W   = REQ_RBIT_LSB + 1;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Result payload layout, lowest bit first.
   localparam int RSP_USED_W   = 1 + 1 + Q_W + 1;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // Request kinds carried on tuser.
   localparam logic REQ_CHOOSE = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 2'd2;

   localparam logic [COEF_W-1:0] ALPHA_RST   = 16'd6554;
   localparam logic [COEF_W-1:0] GAMMA_RST   = 16'd58982;
   localparam logic [PCT_W-1:0]  EPSILON_RST = 7'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the request and read both table rows
      logic eval;       // choose decision, or discounted maximum and current value
      logic diff;       // temporal difference
      logic mul;        // scale by alpha
      logic write_row;  // clamp, write the row back, hold the result
      logic load_out;   // move the held result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic is_update;
   } dp_status_type;

endpackage

// ===== rtl/core/tql_ctrl.sv =====
// Sequencing state machine and result handshake for the Q-learning agent.
// Depends on tql_pkg; drives tql_dp through dp_cmd_type commands.

module tql_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tql_pkg::dp_status_type status,
   output tql_pkg::dp_cmd_type    cmd
);
   import tql_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DIFF,
      S_MUL,
      S_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.is_update ? S_DIFF : S_DONE;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_row = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // The result waits here until the output register is free.
            cmd.load_out = slot_free;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Only update requests write the table.
   a_write_only_update: assert property (@(posedge clock) disable iff (reset)
      cmd.write_row |-> status.is_update)
      else $error("table write during a choose request");

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while stalled");

   // An accepted request always proceeds to evaluation.
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EVAL))
      else $error("accepted request did not start evaluation");

   // A new result appears only after the completion state.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result presented outside completion");

endmodule

// ===== rtl/core/tql_dp.sv =====
// Datapath of the Q-learning agent: value table, policy decision and update arithmetic.
// Depends on tql_pkg; sequenced by tql_ctrl.

module tql_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  tql_pkg::dp_cmd_type               cmd,
   output tql_pkg::dp_status_type            status,
   input  logic                              req_kind,
   input  logic [tql_pkg::REQ_DATA_W-1:0]    req_data,
   input  logic [tql_pkg::COEF_W-1:0]        alpha_coef,
   input  logic [tql_pkg::COEF_W-1:0]        gamma_coef,
   input  logic [tql_pkg::PCT_W-1:0]         explore_percent,
   output logic [tql_pkg::RSP_DATA_W-1:0]    rsp_data
);
   import tql_pkg::*;

   localparam int GM_P_W = COEF_W + 1 + Q_W;        // gamma times maximum
   localparam int GM_W   = GM_P_W - 16;
   localparam int DIFF_W = Q_W + 3;
   localparam int AL_P_W = COEF_W + 1 + DIFF_W;     // alpha times difference
   localparam int STEP_W = AL_P_W - 16;
   localparam int SUM_W  = STEP_W + 1;

   localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-64'sh8000_0000);

   // Latched request.
   logic                       kind_ff;
   logic [STATE_W-1:0]         cur_ff;
   logic                       act_ff;
   logic signed [REWARD_W-1:0] reward_ff;
   logic [PCT_W-1:0]           rpct_ff;
   logic                       rbit_ff;

   // Value table with a valid bit per row; a row never written reads as zero.
   logic [ROW_W-1:0]      mem [NUM_STATES];
   logic [NUM_STATES-1:0] vld_ff;
   logic [ROW_W-1:0]      rd_cur_ff, rd_nxt_ff;
   logic                  rdv_cur_ff, rdv_nxt_ff;

   logic [STATE_W-1:0]    in_cur, in_nxt;
   logic [ROW_W-1:0]      row_cur, row_nxt;
   logic signed [Q_W-1:0] q_cur0, q_cur1, q_nxt0, q_nxt1;
   logic signed [Q_W-1:0] max_nxt, cur_q;

   logic signed [COEF_W:0]    gam_s, alp_s;
   logic signed [GM_P_W-1:0]  gm_prod_in;
   logic signed [GM_W-1:0]    gm_ff;
   logic signed [Q_W-1:0]     curq_ff;
   logic signed [DIFF_W-1:0]  diff_in, diff_ff;
   logic signed [AL_P_W-1:0]  al_prod_in;
   logic signed [STEP_W-1:0]  step_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [Q_W-1:0]     new_q_in;
   logic                      sat_in;
   logic [ROW_W-1:0]          wr_row_in;
   logic                      explore_in, choice_in;

   logic                  res_action_ff, res_explored_ff, res_sat_ff;
   logic signed [Q_W-1:0] res_value_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign in_cur = req_data[REQ_CUR_LSB +: STATE_W];
   assign in_nxt = req_data[REQ_NXT_LSB +: STATE_W];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         cur_ff     <= in_cur;
         act_ff     <= req_data[REQ_ACT_LSB];
         reward_ff  <= req_data[REQ_RWD_LSB +: REWARD_W];
         rpct_ff    <= req_data[REQ_PCT_LSB +: PCT_W];
         rbit_ff    <= req_data[REQ_RBIT_LSB];
         rd_cur_ff  <= mem[in_cur];
         rd_nxt_ff  <= mem[in_nxt];
         rdv_cur_ff <= vld_ff[in_cur];
         rdv_nxt_ff <= vld_ff[in_nxt];
      end
      if (cmd.write_row) begin
         mem[cur_ff] <= wr_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.write_row) begin
         vld_ff[cur_ff] <= 1'b1;
      end
   end

   assign row_cur = rdv_cur_ff ? rd_cur_ff : '0;
   assign row_nxt = rdv_nxt_ff ? rd_nxt_ff : '0;
   assign q_cur0  = row_cur[Q_W-1:0];
   assign q_cur1  = row_cur[ROW_W-1:Q_W];
   assign q_nxt0  = row_nxt[Q_W-1:0];
   assign q_nxt1  = row_nxt[ROW_W-1:Q_W];
   assign max_nxt = (q_nxt1 > q_nxt0) ? q_nxt1 : q_nxt0;
   assign cur_q   = act_ff ? q_cur1 : q_cur0;

   // Policy: explore when the draw falls below epsilon, otherwise take the greater value.
   assign explore_in = (rpct_ff < explore_percent);
   assign choice_in  = explore_in ? rbit_ff : (q_cur1 > q_cur0);

   // Arithmetic right shifts of the products give the floor of the Q16.16 result.
   assign gam_s      = $signed({1'b0, gamma_coef});
   assign alp_s      = $signed({1'b0, alpha_coef});
   assign gm_prod_in = GM_P_W'(gam_s) * GM_P_W'(max_nxt);
   assign diff_in    = $signed({{(DIFF_W - REWARD_W - 16){reward_ff[REWARD_W-1]}},
                                reward_ff, 16'b0})
                       + DIFF_W'(gm_ff) - DIFF_W'(curq_ff);
   assign al_prod_in = AL_P_W'(alp_s) * AL_P_W'(diff_ff);
   assign sum_in     = SUM_W'(curq_ff) + SUM_W'(step_ff);

   always_comb begin
      sat_in   = 1'b0;
      new_q_in = sum_in[Q_W-1:0];
      if (sum_in > Q_MAX) begin
         sat_in   = 1'b1;
         new_q_in = Q_MAX[Q_W-1:0];
      end else if (sum_in < Q_MIN) begin
         sat_in   = 1'b1;
         new_q_in = Q_MIN[Q_W-1:0];
      end
   end

   // The untouched action value of the row is written back unchanged.
   assign wr_row_in = act_ff ? {new_q_in, q_cur0} : {q_cur1, new_q_in};

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         gm_ff   <= gm_prod_in[GM_P_W-1:16];
         curq_ff <= cur_q;
      end
      if (cmd.diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.mul) begin
         step_ff <= al_prod_in[AL_P_W-1:16];
      end
      if (cmd.eval && (kind_ff == REQ_CHOOSE)) begin
         res_action_ff   <= choice_in;
         res_explored_ff <= explore_in;
         res_value_ff    <= '0;
         res_sat_ff      <= 1'b0;
      end else if (cmd.write_row) begin
         res_action_ff   <= 1'b0;
         res_explored_ff <= 1'b0;
         res_value_ff    <= new_q_in;
         res_sat_ff      <= sat_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {{(RSP_DATA_W - RSP_USED_W){1'b0}}, res_sat_ff, res_value_ff,
                         res_explored_ff, res_action_ff};
      end
   end

   assign rsp_data         = rsp_data_ff;
   assign status.is_update = (kind_ff == REQ_UPDATE);

endmodule

// ===== rtl/core/tabular_q_learning_agent.sv =====
// Top level of the tabular Q-learning agent: configuration registers and the
// controller and datapath. Depends on tql_pkg, tql_ctrl and tql_dp.
//
// Requests arrive on the req_ stream; req_tuser selects choose (0) or update (1),
// and each request yields exactly one transfer on the rsp_ stream. A choose
// request returns the epsilon-greedy action and whether it came from the random
// branch; an update request writes the new Q16.16 value back into the table and
// returns it with a saturation flag. The user must write alpha, gamma and epsilon
// via the csr_ port only while no request is outstanding; nothing enforces it.
//
// One request is processed at a time. A choose request passes through the table
// read and the decision; an update request through the table read, the discounted
// maximum, the difference, the alpha multiply, and the clamp and write-back. Each
// result then moves into the output register, and req_tready rises again in the
// cycle after that.
//
// Reset clears every table entry to zero at once through per-row valid bits and
// restores the default coefficients. While the receiver stalls the result is held
// in the output register; one further request may be taken and processed, and it
// then waits until the output register is free.

module tabular_q_learning_agent (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata fields from bit 0: cur_state, taken_action, reward_value,
   // following_state, random_percent, random_bit, zero padding
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tql_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,   // req_type
   // rsp_tdata fields from bit 0: chosen_action, explored, new_value,
   // saturated, zero padding
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tql_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tql_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tql_pkg::COEF_W-1:0]        csr_wdata
);
   import tql_pkg::*;

   logic [COEF_W-1:0] alpha_coef_ff;
   logic [COEF_W-1:0] gamma_coef_ff;
   logic [PCT_W-1:0]  explore_percent_ff;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Writes to an index beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_coef_ff      <= ALPHA_RST;
         gamma_coef_ff      <= GAMMA_RST;
         explore_percent_ff <= EPSILON_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: begin
               alpha_coef_ff <= csr_wdata;
            end
            CSR_GAMMA: begin
               gamma_coef_ff <= csr_wdata;
            end
            CSR_EPSILON: begin
               explore_percent_ff <= csr_wdata[PCT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tql_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tql_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_tuser),
      .req_data        (req_tdata),
      .alpha_coef      (alpha_coef_ff),
      .gamma_coef      (gamma_coef_ff),
      .explore_percent (explore_percent_ff),
      .rsp_data        (rsp_tdata)
   );

endmodule

// ===== bench/tabular_q_learning_agent_tb.sv =====
// Self-checking testbench for the tabular Q-learning agent: directed and random
// choose and update requests, predicted in place and compared field by field.
// Depends on tql_pkg and tabular_q_learning_agent.
`timescale 1ns / 100ps

module tabular_q_learning_agent_tb;
   import tql_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint signed Q_MAX = 64'sd2147483647;
   localparam longint signed Q_MIN = -Q_MAX - 1;

   typedef struct packed {
      logic                        kind;
      logic [STATE_W-1:0]          cur;
      logic                        act;
      logic signed [REWARD_W-1:0]  reward;
      logic [STATE_W-1:0]          nxt;
      logic [PCT_W-1:0]            pct;
      logic                        rbit;
   } agent_request_type;

   typedef struct packed {
      logic                        chosen;
      logic                        explored;
      logic signed [Q_W-1:0]       value;
      logic                        saturated;
   } agent_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = REQ_CHOOSE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [COEF_W-1:0]       csr_wdata  = '0;

   // Model of the agent: its own copy of the table and of the coefficients.
   logic signed [Q_W-1:0]   q_model [NUM_STATES][2];
   logic [COEF_W-1:0]       alpha_q     = ALPHA_RST;
   logic [COEF_W-1:0]       gamma_q     = GAMMA_RST;
   logic [PCT_W-1:0]        epsilon_pct = EPSILON_RST;

   agent_request_type       queued_requests [$];
   agent_outcome_type       pending_outcomes [$];
   agent_request_type       req_item;
   agent_request_type       next_req;
   logic [REQ_DATA_W-1:0]   req_word;
   agent_outcome_type       seen_outcome;
   agent_outcome_type       due_outcome;

   int  req_wait = 0;
   int  rsp_stall = 0;
   int  rsp_gap;
   bit  req_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;
   int  mismatch_count = 0;

   tabular_q_learning_agent uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Works out the reply to one request and applies any table write.
   function automatic agent_outcome_type predict_agent_step(agent_request_type r);
      agent_outcome_type o;
      longint signed cur, best, a_l, g_l, rw, diff, nv;
      o = '0;
      if (r.kind == REQ_CHOOSE) begin
         o.explored = (r.pct < epsilon_pct);
         o.chosen   = o.explored ? r.rbit : (q_model[r.cur][1] > q_model[r.cur][0]);
      end else begin
         best = (q_model[r.nxt][1] > q_model[r.nxt][0]) ? longint'(q_model[r.nxt][1])
                                                       : longint'(q_model[r.nxt][0]);
         cur  = longint'(q_model[r.cur][r.act]);
         a_l  = longint'(alpha_q);
         g_l  = longint'(gamma_q);
         rw   = longint'(r.reward);
         // Both shifts are arithmetic, so the scaling rounds towards minus infinity.
         diff = rw * 65536 + ((g_l * best) >>> 16) - cur;
         nv   = cur + ((a_l * diff) >>> 16);
         if (nv > Q_MAX) begin
            nv = Q_MAX;
            o.saturated = 1'b1;
         end else if (nv < Q_MIN) begin
            nv = Q_MIN;
            o.saturated = 1'b1;
         end
         q_model[r.cur][r.act] = nv[Q_W-1:0];
         o.value = nv[Q_W-1:0];
      end
      return o;
   endfunction

   function automatic void report_mismatch(string field, longint signed want,
                                           longint signed got);
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
   endfunction

   // Request driver: one item at a time from the queue, with a drawn gap after each.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(predict_agent_step(req_item));
         if (req_tvalid && !req_tready) begin
            // Transfer still pending: hold everything.
         end else if (req_wait != 0) begin
            req_wait   <= req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            next_req = queued_requests.pop_front();
            req_word = '0;
            req_word[REQ_USED_W-1:0] = {next_req.rbit, next_req.pct, next_req.nxt,
                                        next_req.reward, next_req.act, next_req.cur};
            req_item   <= next_req;
            req_tdata  <= req_word;
            req_tuser  <= next_req.kind;
            req_tvalid <= 1'b1;
            req_wait   <= req_quiet ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 31) == 0)
               req_quiet <= !req_quiet;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each transfer and stalls for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen_outcome.chosen    = rsp_tdata[0];
         seen_outcome.explored  = rsp_tdata[1];
         seen_outcome.value     = rsp_tdata[Q_W+1:2];
         seen_outcome.saturated = rsp_tdata[Q_W+2];
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatch_count++;
         end else begin
            due_outcome = pending_outcomes.pop_front();
            if (seen_outcome.chosen !== due_outcome.chosen)
               report_mismatch("chosen_action", longint'(due_outcome.chosen),
                               longint'(seen_outcome.chosen));
            if (seen_outcome.explored !== due_outcome.explored)
               report_mismatch("explored", longint'(due_outcome.explored),
                               longint'(seen_outcome.explored));
            if (seen_outcome.value !== due_outcome.value)
               report_mismatch("new_value", longint'(due_outcome.value),
                               longint'(seen_outcome.value));
            if (seen_outcome.saturated !== due_outcome.saturated)
               report_mismatch("saturated", longint'(due_outcome.saturated),
                               longint'(seen_outcome.saturated));
         end
         rsp_gap = rsp_quiet ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 31) == 0)
            rsp_quiet <= !rsp_quiet;
         rsp_stall  <= rsp_gap;
         rsp_tready <= (rsp_gap == 0);
      end else if (rsp_stall != 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic agent_request_type make_request(
      input logic kind, input logic [STATE_W-1:0] cur, input logic act,
      input logic signed [REWARD_W-1:0] reward, input logic [STATE_W-1:0] nxt,
      input logic [PCT_W-1:0] pct, input logic rbit);
      agent_request_type r;
      r.kind   = kind;
      r.cur    = cur;
      r.act    = act;
      r.reward = reward;
      r.nxt    = nxt;
      r.pct    = pct;
      r.rbit   = rbit;
      return r;
   endfunction

   function automatic logic signed [REWARD_W-1:0] draw_reward();
      case ($urandom_range(0, 7))
         0:       return 11'sd1023;
         1:       return -11'sd1024;
         2, 3, 4: return REWARD_W'($urandom_range(0, 16) - 8);
         default: return REWARD_W'($urandom);
      endcase
   endfunction

   // A walk through a neighbourhood of states: choose, then update the state left.
   task automatic add_episode(input int span, input int steps);
      logic [STATE_W-1:0] base_state, walk_state, following;
      logic [PCT_W-1:0]   draw;
      base_state = STATE_W'($urandom);
      walk_state = base_state + STATE_W'($urandom_range(0, span));
      repeat (steps) begin
         if ($urandom_range(0, 7) == 0) begin
            // Stray request with every field random.
            queued_requests.push_back(make_request(1'($urandom), STATE_W'($urandom),
               1'($urandom), REWARD_W'($urandom), STATE_W'($urandom),
               PCT_W'($urandom), 1'($urandom)));
         end else begin
            draw = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(0, 127))
                                               : PCT_W'($urandom_range(0, 99));
            following = base_state + STATE_W'($urandom_range(0, span));
            queued_requests.push_back(make_request(REQ_CHOOSE, walk_state, 1'($urandom),
               REWARD_W'($urandom), STATE_W'($urandom), draw, 1'($urandom)));
            queued_requests.push_back(make_request(REQ_UPDATE, walk_state, 1'($urandom),
               draw_reward(), following, PCT_W'($urandom), 1'($urandom)));
            walk_state = following;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ALPHA:   alpha_q     = val;
         CSR_GAMMA:   gamma_q     = val;
         CSR_EPSILON: epsilon_pct = val[PCT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_until_drained();
      while (queued_requests.size() != 0 || req_tvalid || pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      for (int s = 0; s < NUM_STATES; s++) begin
         q_model[s][0] = '0;
         q_model[s][1] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: exploration threshold edges, ties and both reward extremes.
      @(negedge clock);
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 99, 1));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 0, 1));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 9, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 10, 1));
      queued_requests.push_back(make_request(REQ_CHOOSE, 127, 0, 0, 0, 127, 1));
      queued_requests.push_back(make_request(REQ_CHOOSE, 64, 1, 1023, 85, 42, 1));
      queued_requests.push_back(make_request(REQ_UPDATE, 0, 1, 1023, 0, 0, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 50, 0));
      queued_requests.push_back(make_request(REQ_UPDATE, 127, 0, -1024, 127, 127, 1));
      queued_requests.push_back(make_request(REQ_UPDATE, 127, 1, -1024, 0, 0, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 127, 0, 0, 0, 99, 0));
      queued_requests.push_back(make_request(REQ_UPDATE, 5, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_request(REQ_UPDATE, 5, 1, 0, 127, 0, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 5, 0, 0, 0, 10, 1));
      queued_requests.push_back(make_request(REQ_UPDATE, 0, 0, 1023, 0, 0, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 10, 0));
      queued_requests.push_back(make_request(REQ_UPDATE, 0, 0, 1, 0, 0, 0));
      queued_requests.push_back(make_request(REQ_CHOOSE, 0, 0, 0, 0, 99, 1));

      // Full-scale coefficients drive a self-referencing state into both clamps.
      wait_until_drained();
      write_csr(CSR_ALPHA, 16'hFFFF);
      write_csr(CSR_GAMMA, 16'hFFFF);
      write_csr(CSR_EPSILON, 16'd0);
      @(negedge clock);
      repeat (40)
         queued_requests.push_back(make_request(REQ_UPDATE, 3, 1'($urandom),
            REWARD_W'(1023 - $urandom_range(0, 123)), 3, PCT_W'($urandom),
            1'($urandom)));
      queued_requests.push_back(make_request(REQ_CHOOSE, 3, 0, 0, 0, 0, 1));
      repeat (40)
         queued_requests.push_back(make_request(REQ_UPDATE, 4, 1'($urandom),
            REWARD_W'($urandom_range(0, 123) - 1024), 4, PCT_W'($urandom),
            1'($urandom)));
      queued_requests.push_back(make_request(REQ_CHOOSE, 4, 0, 0, 0, 0, 1));

      // Frozen table; draws under 100 explore; the spare index must change nothing.
      wait_until_drained();
      write_csr(CSR_ALPHA, 16'd0);
      write_csr(CSR_GAMMA, 16'd0);
      write_csr(CSR_EPSILON, 16'd100);
      write_csr(CSR_SPARE, 16'($urandom));
      @(negedge clock);
      add_episode(7, 75);

      // Threshold beyond the nominal range, smallest non-zero coefficients.
      wait_until_drained();
      write_csr(CSR_ALPHA, 16'd1);
      write_csr(CSR_GAMMA, 16'd1);
      write_csr(CSR_EPSILON, 16'd127);
      @(negedge clock);
      add_episode(127, 75);

      for (int phase = 0; phase < 7; phase++) begin
         wait_until_drained();
         write_csr(CSR_ALPHA, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
         write_csr(CSR_GAMMA, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
         write_csr(CSR_EPSILON, (phase == 0) ? 16'd0 : 16'($urandom_range(0, 100)));
         @(negedge clock);
         case ($urandom_range(0, 2))
            0:       add_episode(3, 104);
            1:       add_episode(15, 104);
            default: add_episode(127, 104);
         endcase
      end

      wait_until_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tql_pkg.sv
rtl/core/tql_ctrl.sv
rtl/core/tql_dp.sv
rtl/core/tabular_q_learning_agent.sv
bench/tabular_q_learning_agent_tb.sv
